// File: src/sfbr_pkg.sv
// Shared constants and types of the serpentine frame buffer rotator.
// No dependencies; compiled first.
package sfbr_pkg;

   localparam int SIDE_DEFAULT = 16;   // pixels along one edge of the square image

   localparam int KindW   = 2;
   localparam int CoordW  = 5;
   localparam int ColorW  = 24;
   localparam int TurnsW  = 2;

   // transaction kinds on the request channel
   typedef enum logic [KindW-1:0] {
      KIND_WRITE  = 2'd0,
      KIND_READ   = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_ROTATE = 2'd3
   } kind_type;

endpackage

// File: src/sfbr_req_if.sv
// Request channel of the frame buffer: valid/ready plus one operation.
// Depends on sfbr_pkg.
interface sfbr_req_if;
   import sfbr_pkg::*;

   logic              valid;
   logic              ready;
   logic [KindW-1:0]  kind;
   logic [CoordW-1:0] x_coord;
   logic [CoordW-1:0] y_coord;
   logic [ColorW-1:0] pixel_color;

   modport source (output valid, kind, x_coord, y_coord, pixel_color, input ready);
   modport sink   (input valid, kind, x_coord, y_coord, pixel_color, output ready);
endinterface

// File: src/sfbr_rsp_if.sv
// Response channel of the frame buffer: valid/ready plus read data and error flag.
// Depends on sfbr_pkg.
interface sfbr_rsp_if;
   import sfbr_pkg::*;

   logic              valid;
   logic              ready;
   logic [ColorW-1:0] read_color;
   logic              coord_error;

   modport source (output valid, read_color, coord_error, input ready);
   modport sink   (input valid, read_color, coord_error, output ready);
endinterface

// File: src/serpentine_frame_buffer_rotator.sv
// Serpentine LED frame buffer with write, read, clear and in-place rotate.
// Depends on sfbr_pkg, sfbr_req_if and sfbr_rsp_if.
//
// A SIDE x SIDE image of 24-bit 0xRRGGBB pixels held in serpentine order
// (odd rows run forward, even rows backward, 1-based coordinates). Every
// request transaction gives exactly one response transaction. Writes and
// reads are taken one per cycle while idle and the response path is not
// stalled; a read's data comes back through a one-entry pipeline stage and
// the output register, so back-to-back reads stream at full rate. A clear
// holds off new requests while it sweeps the memory (one memory entry per
// cycle), a rotate while it runs its quarter turns: each quarter turn copies
// the image through the single read port into the other half of a
// double-size memory, one pixel per cycle, then drains the last write. The
// response of a clear or rotate takes the same two-stage path and does not
// wait for the sweep to finish. After reset the block runs a clearing pass
// over the live image before it takes its first request;
// csr writes are taken at any time but only belong while the block is idle.
// Out-of-range coordinates on write or read set coord_error and do not touch
// the image.
module serpentine_frame_buffer_rotator
#(
   parameter int SIDE = sfbr_pkg::SIDE_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [sfbr_pkg::TurnsW-1:0] csr_write_data,
   sfbr_req_if.sink                  req_chan,
   sfbr_rsp_if.source                rsp_chan
);

   import sfbr_pkg::*;

   localparam int CELLS  = SIDE * SIDE;
   localparam int CW     = $clog2(SIDE);        // 0-based row/column index
   localparam int AW     = $clog2(CELLS);       // slot within one image
   localparam int SideLim = (SIDE > 31) ? 31 : SIDE;
   localparam logic [CW-1:0]     ColMax  = CW'(SIDE - 1);
   localparam logic [AW-1:0]     SideA   = AW'(SIDE);
   localparam logic [AW-1:0]     CellMax = AW'(CELLS - 1);
   localparam logic [CoordW-1:0] CoordLim = CoordW'(SideLim);

   typedef enum logic [3:0] {
      S_CLEAR    = 4'b0001,   // sweeping zeros through the live image
      S_IDLE     = 4'b0010,
      S_ROT      = 4'b0100,   // copying one quarter turn into the spare half
      S_ROT_LAST = 4'b1000    // last pending write, then swap halves
   } state_type;

   // 0-based column/row to serpentine slot
   function automatic logic [AW-1:0] slot_of0(input logic [CW-1:0] col0,
                                              input logic [CW-1:0] row0);
      logic [AW-1:0] base;
      logic [CW-1:0] offs;
      base = AW'(row0) * SideA;
      offs = row0[0] ? (ColMax - col0) : col0;
      return base + AW'(offs);
   endfunction

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic              bank_ff, bank_in;          // which half holds the live image
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in; // destination pixel of the turn
   logic [TurnsW-1:0] turns_ff;                  // csr
   logic [TurnsW-1:0] turns_left_ff, turns_left_in;
   logic              wr_pend_ff, wr_pend_in;    // rotate copy write owed
   logic [AW-1:0]     dest_d_ff, dest_d_in;

   // pipeline stage between acceptance and the output register
   logic              p1_valid_ff, p1_valid_in;
   logic              p1_read_ff, p1_read_in;
   logic              p1_err_ff, p1_err_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ColorW-1:0] rsp_color_ff, rsp_color_in;
   logic              rsp_err_ff, rsp_err_in;

   // memory: two image halves, bank bit on top of the slot address
   logic [ColorW-1:0] pixel_store_ff [2**(AW+1)];
   logic [ColorW-1:0] rd_data_ff;
   logic              rd_en;
   logic [AW:0]       rd_addr;
   logic              wr_en;
   logic [AW:0]       wr_addr;
   logic [ColorW-1:0] wr_data;

   // ---------------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------------
   logic          out_free, req_fire, coord_ok, is_pix_op;
   logic [CW-1:0] col0, row0;
   logic [AW-1:0] req_slot, rot_src, rot_dst;
   logic          rot_end;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && (!p1_valid_ff || out_free);
   assign req_fire  = req_chan.valid && req_chan.ready;

   assign coord_ok  = (req_chan.x_coord != '0) && (req_chan.x_coord <= CoordLim) &&
                      (req_chan.y_coord != '0) && (req_chan.y_coord <= CoordLim);
   assign is_pix_op = (req_chan.kind == KIND_WRITE) || (req_chan.kind == KIND_READ);
   assign col0      = CW'(req_chan.x_coord - CoordW'(1));
   assign row0      = CW'(req_chan.y_coord - CoordW'(1));
   assign req_slot  = slot_of0(col0, row0);

   // new(x,y) = old(SIDE+1-y, x)
   assign rot_dst   = slot_of0(cx_ff, cy_ff);
   assign rot_src   = slot_of0(ColMax - cy_ff, cx_ff);
   assign rot_end   = (cx_ff == ColMax) && (cy_ff == ColMax);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      clr_cnt_in    = clr_cnt_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      turns_left_in = turns_left_ff;
      wr_pend_in    = 1'b0;
      dest_d_in     = dest_d_ff;
      rd_en         = 1'b0;
      rd_addr       = {bank_ff, req_slot};
      wr_en         = 1'b0;
      wr_addr       = {bank_ff, req_slot};
      wr_data       = req_chan.pixel_color;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = {bank_ff, clr_cnt_ff};
            wr_data = '0;
            if (clr_cnt_ff == CellMax) begin
               clr_cnt_in = '0;
               state_in   = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.kind)
                  KIND_WRITE: wr_en = coord_ok;
                  KIND_READ:  rd_en = coord_ok;
                  KIND_CLEAR: state_in = S_CLEAR;
                  KIND_ROTATE: begin
                     if (turns_ff != '0) begin
                        state_in      = S_ROT;
                        turns_left_in = turns_ff;
                        cx_in         = '0;
                        cy_in         = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ROT: begin
            // write back the pixel read last cycle, read the next one
            wr_en      = wr_pend_ff;
            wr_addr    = {!bank_ff, dest_d_ff};
            wr_data    = rd_data_ff;
            rd_en      = 1'b1;
            rd_addr    = {bank_ff, rot_src};
            wr_pend_in = 1'b1;
            dest_d_in  = rot_dst;
            if (rot_end) begin
               state_in = S_ROT_LAST;
               cx_in    = '0;
               cy_in    = '0;
            end else if (cx_ff == ColMax) begin
               cx_in = '0;
               cy_in = cy_ff + CW'(1);
            end else begin
               cx_in = cx_ff + CW'(1);
            end
         end
         S_ROT_LAST: begin
            wr_en         = wr_pend_ff;
            wr_addr       = {!bank_ff, dest_d_ff};
            wr_data       = rd_data_ff;
            bank_in       = !bank_ff;
            turns_left_in = turns_left_ff - TurnsW'(1);
            state_in      = (turns_left_ff == TurnsW'(1)) ? S_IDLE : S_ROT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Response pipeline
   // ---------------------------------------------------------------------
   always_comb begin
      p1_valid_in  = p1_valid_ff;
      p1_read_in   = p1_read_ff;
      p1_err_in    = p1_err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      rsp_err_in   = rsp_err_ff;

      if (out_free) begin
         rsp_valid_in = p1_valid_ff;
         rsp_color_in = p1_read_ff ? rd_data_ff : '0;
         rsp_err_in   = p1_err_ff;
         p1_valid_in  = 1'b0;
      end
      if (req_fire) begin
         p1_valid_in = 1'b1;
         p1_read_in  = (req_chan.kind == KIND_READ) && coord_ok;
         p1_err_in   = is_pix_op && !coord_ok;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_color  = rsp_color_ff;
   assign rsp_chan.coord_error = rsp_err_ff;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         bank_ff       <= 1'b0;
         clr_cnt_ff    <= '0;
         cx_ff         <= '0;
         cy_ff         <= '0;
         turns_ff      <= '0;
         turns_left_ff <= '0;
         wr_pend_ff    <= 1'b0;
         p1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bank_ff       <= bank_in;
         clr_cnt_ff    <= clr_cnt_in;
         cx_ff         <= cx_in;
         cy_ff         <= cy_in;
         turns_left_ff <= turns_left_in;
         wr_pend_ff    <= wr_pend_in;
         p1_valid_ff   <= p1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_en) begin
            turns_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      dest_d_ff    <= dest_d_in;
      p1_read_ff   <= p1_read_in;
      p1_err_ff    <= p1_err_in;
      rsp_color_ff <= rsp_color_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // image memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pixel_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= pixel_store_ff[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_rot_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_chan.kind == KIND_ROTATE) && (turns_ff != '0) |=> state_ff == S_ROT)
      else $error("rotate did not start its copy");

   a_bank_swap: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROT_LAST |=> bank_ff != $past(bank_ff))
      else $error("image halves not swapped after a turn");

   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_color_ff == '0)
      else $error("coordinate error carries read data");

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_chan.ready)
      else $error("request taken while sweeping the memory");

   a_wr_pend_rot: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (state_ff == S_ROT) || (state_ff == S_ROT_LAST))
      else $error("copy write owed outside a rotate");

endmodule

// File: tb/tb_serpentine_frame_buffer_rotator.sv
`timescale 1ns / 1ps
// Self-checking testbench for serpentine_frame_buffer_rotator: directed and random
// pixel traffic with a scoreboard class that mirrors the image. Depends on sfbr_pkg,
// sfbr_req_if, sfbr_rsp_if and the RTL top level.

module tb_serpentine_frame_buffer_rotator;

   import sfbr_pkg::*;

   // Mirror of the frame buffer image plus the queue of responses still owed.
   class pixel_scoreboard;
      logic [ColorW-1:0] image [SIDE_DEFAULT*SIDE_DEFAULT];
      logic [TurnsW-1:0] turns;
      logic [ColorW-1:0] owed_color [$];
      logic              owed_error [$];
      int unsigned       mismatches;

      function new();
         foreach (image[i]) image[i] = '0;
         turns      = '0;
         mismatches = 0;
      endfunction

      function void set_turns(logic [TurnsW-1:0] value);
         turns = value;
      endfunction

      function int pending();
         return owed_color.size();
      endfunction

      // serpentine: odd rows run forward, even rows backward (1-based)
      function int slot_of(int x, int y);
         int base;
         base = (y - 1) * SIDE_DEFAULT;
         return (y % 2 == 1) ? base + x - 1 : base + SIDE_DEFAULT - x;
      endfunction

      function bit coord_ok(int v);
         return v >= 1 && v <= SIDE_DEFAULT;
      endfunction

      // new(x,y) = old(SIDE+1-y, x)
      function void quarter_turn();
         logic [ColorW-1:0] turned [SIDE_DEFAULT*SIDE_DEFAULT];
         for (int y = 1; y <= SIDE_DEFAULT; y++)
            for (int x = 1; x <= SIDE_DEFAULT; x++)
               turned[slot_of(x, y)] = image[slot_of(SIDE_DEFAULT + 1 - y, x)];
         image = turned;
      endfunction

      function void note_request(kind_type op, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                 logic [ColorW-1:0] color);
         logic [ColorW-1:0] read_back;
         logic              bad;
         read_back = '0;
         bad       = !(coord_ok(int'(x)) && coord_ok(int'(y)));
         unique case (op)
            KIND_WRITE: begin
               if (!bad) image[slot_of(x, y)] = color;
            end
            KIND_READ: begin
               if (!bad) read_back = image[slot_of(x, y)];
            end
            KIND_CLEAR: begin
               foreach (image[i]) image[i] = '0;
               bad = 1'b0;
            end
            default: begin
               repeat (turns) quarter_turn();
               bad = 1'b0;
            end
         endcase
         owed_color.push_back(read_back);
         owed_error.push_back(bad);
      endfunction

      function void check_response(logic [ColorW-1:0] color, logic error);
         logic [ColorW-1:0] want_color;
         logic              want_error;
         if (owed_color.size() == 0) begin
            $error("response with nothing owed: read_color=%h coord_error=%b", color, error);
            mismatches++;
            return;
         end
         want_color = owed_color.pop_front();
         want_error = owed_error.pop_front();
         if (color !== want_color) begin
            $error("read_color: expected %h, actual %h", want_color, color);
            mismatches++;
         end
         if (error !== want_error) begin
            $error("coord_error: expected %b, actual %b", want_error, error);
            mismatches++;
         end
      endfunction
   endclass

   localparam int SIDE         = SIDE_DEFAULT;
   localparam int CELLS        = SIDE * SIDE;
   // a rotate can keep the block busy for up to three quarter turns after its response
   localparam int SETTLE       = 3 * (CELLS + 1) + 16;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 200;
   localparam int CYCLE_LIMIT  = 600000;

   logic clock;
   logic reset;
   logic              csr_write_en;
   logic [TurnsW-1:0] csr_write_data;

   sfbr_req_if req_bus ();
   sfbr_rsp_if rsp_bus ();

   serpentine_frame_buffer_rotator #(
      .SIDE (SIDE)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus)
   );

   pixel_scoreboard board;

   // idle percentages used by the sender and receiver processes
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_ask = 1'b0;     // asks the receiver for one long hold-off

   // recent valid write coordinates, so reads often land on painted pixels
   logic [2*CoordW-1:0] painted [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Global watchdog: the run fails if it does not finish before the cycle limit.
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("** serpentine_frame_buffer_rotator: FAILED **");
      $finish;
   end

   // Monitor: notes the accepted request before checking the response of the
   // same edge, so a response issued at acceptance still finds its expectation.
   always @(posedge clock) begin
      if (!reset && board != null) begin
         if (req_bus.valid && req_bus.ready)
            board.note_request(kind_type'(req_bus.kind), req_bus.x_coord, req_bus.y_coord,
                               req_bus.pixel_color);
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_response(rsp_bus.read_color, rsp_bus.coord_error);
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_left = HOLD_CYCLES;
            hold_ask  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offer one transaction; returns on the edge where it was accepted. Valid is
   // only dropped when an idle gap follows, so back-to-back items keep it high.
   task automatic send_item(input kind_type op, input logic [CoordW-1:0] x,
                            input logic [CoordW-1:0] y, input logic [ColorW-1:0] color);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= op;
      req_bus.x_coord     <= x;
      req_bus.y_coord     <= y;
      req_bus.pixel_color <= color;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   function automatic logic [CoordW-1:0] pick_coord();
      // mostly on the image, sometimes anywhere in the 5-bit range
      if ($urandom_range(9) == 0) return CoordW'($urandom_range(31));
      return CoordW'($urandom_range(SIDE, 1));
   endfunction

   function automatic logic [ColorW-1:0] pick_color();
      int unsigned roll;
      roll = $urandom_range(19);
      if (roll == 0) return '0;
      if (roll < 3)  return '1;
      return ColorW'($urandom);
   endfunction

   task automatic send_random_item();
      int unsigned       roll;
      kind_type          op;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [ColorW-1:0] color;
      logic [2*CoordW-1:0] spot;
      roll  = $urandom_range(999);
      x     = pick_coord();
      y     = pick_coord();
      color = pick_color();
      if (roll < 480)      op = KIND_WRITE;
      else if (roll < 950) op = KIND_READ;
      else if (roll < 956) op = KIND_CLEAR;   // rare, so the image fills up
      else                 op = KIND_ROTATE;
      if (op == KIND_READ && painted.size() > 0 && $urandom_range(1) == 1) begin
         spot = painted[$urandom_range(painted.size() - 1)];
         {x, y} = spot;
      end
      if (op == KIND_WRITE && x >= 1 && x <= SIDE && y >= 1 && y <= SIDE) begin
         painted.push_back({x, y});
         if (painted.size() > 32) void'(painted.pop_front());
      end
      send_item(op, x, y, color);
   endtask

   // Stop offering, wait for every owed response, then for a possible rotate
   // still walking the store, before touching the register.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_turns(input logic [TurnsW-1:0] value);
      wait_idle();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      board.set_turns(value);
   endtask

   task automatic run_phase(input logic [TurnsW-1:0] value, input int unsigned idle_pct,
                            input int unsigned stall_pct, input bit squeeze);
      write_turns(value);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (squeeze) hold_ask = 1'b1;   // receiver backs off while items keep coming
      repeat (PHASE_ITEMS) send_random_item();
   endtask

   // Directed: corners, extreme coordinates and colors, bad coordinates on both
   // read and write, a zero-turn rotate, a single-turn rotate, and a clear.
   task automatic run_directed();
      write_turns(2'd0);
      send_item(KIND_WRITE, 5'd1, 5'd1, 24'hFFFFFF);
      send_item(KIND_WRITE, 5'd16, 5'd1, 24'h000001);
      send_item(KIND_WRITE, 5'd1, 5'd16, 24'h800000);
      send_item(KIND_WRITE, 5'd16, 5'd16, 24'h123456);
      send_item(KIND_WRITE, 5'd0, 5'd5, 24'hBADBAD);     // column zero
      send_item(KIND_WRITE, 5'd5, 5'd17, 24'hBADBAD);    // row past the edge
      send_item(KIND_WRITE, 5'd31, 5'd31, 24'hFFFFFF);
      send_item(KIND_READ, 5'd0, 5'd0, 24'h000000);
      send_item(KIND_ROTATE, 5'd31, 5'd0, 24'hFFFFFF);   // no turns: image untouched
      send_item(KIND_READ, 5'd1, 5'd1, 24'h000000);
      send_item(KIND_READ, 5'd16, 5'd16, 24'h000000);
      send_item(KIND_READ, 5'd1, 5'd16, 24'h000000);     // even row runs backward
      write_turns(2'd1);
      send_item(KIND_ROTATE, 5'd0, 5'd31, 24'h000000);
      send_item(KIND_READ, 5'd1, 5'd1, 24'h000000);
      send_item(KIND_READ, 5'd16, 5'd1, 24'h000000);
      send_item(KIND_READ, 5'd1, 5'd16, 24'h000000);
      send_item(KIND_READ, 5'd16, 5'd16, 24'h000000);
      send_item(KIND_READ, 5'd17, 5'd1, 24'h000000);
      send_item(KIND_CLEAR, 5'd0, 5'd31, 24'hFFFFFF);    // coordinates ignored
      send_item(KIND_READ, 5'd1, 5'd1, 24'h000000);
      send_item(KIND_WRITE, 5'd8, 5'd9, 24'hABCDEF);
      send_item(KIND_READ, 5'd8, 5'd9, 24'h000000);
      send_item(KIND_ROTATE, 5'd31, 5'd31, 24'h5A5A5A);
      send_item(KIND_READ, 5'd8, 5'd8, 24'h000000);
      send_item(KIND_READ, 5'd9, 5'd9, 24'h000000);
   endtask

   initial begin
      board = new();
      reset               <= 1'b1;
      csr_write_en        <= 1'b0;
      csr_write_data      <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= KIND_WRITE;
      req_bus.x_coord     <= '0;
      req_bus.y_coord     <= '0;
      req_bus.pixel_color <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      // turns, sender idle %, receiver stall %, long hold-off
      run_phase(2'd3, 0, 0, 1'b1);
      run_phase(2'd0, 61, 0, 1'b0);
      run_phase(2'd2, 0, 61, 1'b0);
      run_phase(2'd1, 27, 27, 1'b0);
      run_phase(2'd3, 61, 0, 1'b0);
      run_phase(2'd1, 0, 61, 1'b0);
      run_phase(2'd0, 27, 27, 1'b0);
      run_phase(2'd2, 0, 0, 1'b0);
      req_bus.valid <= 1'b0;

      // anything arriving during the settle window shows up as unowed
      wait_idle();
      if (board.mismatches == 0)
         $display("** serpentine_frame_buffer_rotator: PASSED **");
      else
         $display("** serpentine_frame_buffer_rotator: FAILED **");
      $finish;
   end

endmodule
